[design/uhf_pkg.sv]
// shared types, register map and widths for the universal hash block
// no dependencies
package uhf_pkg;

    // field widths
    localparam int WORD_W = 31;
    localparam int KEY_W  = 64;
    localparam int HALF_W = 16;
    localparam int PROD_W = WORD_W + HALF_W;
    localparam int SUM_W  = 50;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // first reduction runs one bit wider so that a zero prime acts as 2^SUM_W
    localparam int MOD1_W = SUM_W + 1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [KEY_W-1:0]  key_t;

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_COEF_0     = 3'd0,
        REG_COEF_1     = 3'd1,
        REG_COEF_2     = 3'd2,
        REG_COEF_3     = 3'd3,
        REG_OFFSET     = 3'd4,
        REG_PRIME      = 3'd5,
        REG_TABLE_SIZE = 3'd6,
        REG_NONE       = 3'd7
    } reg_idx_t;

    localparam word_t PRIME_RESET      = 31'h7FFF_FFFF;
    localparam word_t TABLE_SIZE_RESET = 31'd1;
    localparam key_t  NEG_ZERO         = 64'h8000_0000_0000_0000;

endpackage

[design/universal_hash_float64.sv]
// top level: apb register file, hash pipeline and output skid stage
// depends on uhf_pkg, uhf_sum, uhf_mod
//
// Carter-Wegman hash of a 64-bit key into a table slot. One key transaction
// is taken per cycle while key_stall is low; each result passes the product
// and sum stages, remainders by prime and by table_size, one bit per stage,
// and the output register. Results leave in key order. An output register
// plus one skid entry keep keys flowing while a result waits; key_stall rises
// once both are full and the pipeline holds. The user must write registers
// over APB only while no key is in flight; the block does not enforce this.
// A zero prime skips the first reduction, a zero table_size gives 0.
module universal_hash_float64
    import uhf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              key_valid,
    output logic              key_stall,
    input  logic [KEY_W-1:0]  key_bits,
    output logic              slot_valid,
    input  logic              slot_stall,
    output logic [WORD_W-1:0] slot
);

    word_t coef_0_reg, coef_1_reg, coef_2_reg, coef_3_reg;
    word_t offset_reg, prime_reg, table_size_reg;
    reg_idx_t idx;
    logic adv;
    logic sum_valid;
    sum_t sum;
    logic [MOD1_W-1:0] div1;
    logic m1_valid;
    logic [MOD1_W-1:0] m1_rem;
    logic m2_valid;
    word_t m2_rem;
    word_t pipe_slot;
    logic slot_valid_reg;
    word_t slot_reg;
    logic skid_full_reg;
    word_t skid_reg;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_0_reg     <= '0;
            coef_1_reg     <= '0;
            coef_2_reg     <= '0;
            coef_3_reg     <= '0;
            offset_reg     <= '0;
            prime_reg      <= PRIME_RESET;
            table_size_reg <= TABLE_SIZE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_COEF_0:     coef_0_reg     <= pwdata[WORD_W-1:0];
                REG_COEF_1:     coef_1_reg     <= pwdata[WORD_W-1:0];
                REG_COEF_2:     coef_2_reg     <= pwdata[WORD_W-1:0];
                REG_COEF_3:     coef_3_reg     <= pwdata[WORD_W-1:0];
                REG_OFFSET:     offset_reg     <= pwdata[WORD_W-1:0];
                REG_PRIME:      prime_reg      <= pwdata[WORD_W-1:0];
                REG_TABLE_SIZE: table_size_reg <= pwdata[WORD_W-1:0];
                default:        ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (idx)
            REG_COEF_0:     prdata = {1'b0, coef_0_reg};
            REG_COEF_1:     prdata = {1'b0, coef_1_reg};
            REG_COEF_2:     prdata = {1'b0, coef_2_reg};
            REG_COEF_3:     prdata = {1'b0, coef_3_reg};
            REG_OFFSET:     prdata = {1'b0, offset_reg};
            REG_PRIME:      prdata = {1'b0, prime_reg};
            REG_TABLE_SIZE: prdata = {1'b0, table_size_reg};
            default:        prdata = '0;
        endcase
    end

    // whole pipeline moves unless the skid entry is occupied
    assign adv       = !skid_full_reg;
    assign key_stall = skid_full_reg;

    uhf_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (key_valid),
        .key       (key_bits),
        .coef_0    (coef_0_reg),
        .coef_1    (coef_1_reg),
        .coef_2    (coef_2_reg),
        .coef_3    (coef_3_reg),
        .offset    (offset_reg),
        .out_valid (sum_valid),
        .sum       (sum)
    );

    // zero prime behaves as 2^SUM_W, which leaves the sum unchanged
    assign div1 = (prime_reg == '0) ? {1'b1, {SUM_W{1'b0}}}
                                    : {{(MOD1_W-WORD_W){1'b0}}, prime_reg};

    uhf_mod #(
        .DW (SUM_W),
        .RW (MOD1_W)
    ) u_mod_prime (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sum_valid),
        .dividend  (sum),
        .divisor   (div1),
        .out_valid (m1_valid),
        .rem       (m1_rem)
    );

    uhf_mod #(
        .DW (SUM_W),
        .RW (WORD_W)
    ) u_mod_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (m1_valid),
        .dividend  (m1_rem[SUM_W-1:0]),
        .divisor   (table_size_reg),
        .out_valid (m2_valid),
        .rem       (m2_rem)
    );

    assign pipe_slot = (table_size_reg == '0) ? '0 : m2_rem;

    // output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            skid_full_reg  <= 1'b0;
        end
        else if (!slot_valid_reg || !slot_stall)
        begin
            if (skid_full_reg)
            begin
                slot_valid_reg <= 1'b1;
                skid_full_reg  <= 1'b0;
            end
            else
            begin
                slot_valid_reg <= m2_valid;
            end
        end
        else if (!skid_full_reg && m2_valid)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (!slot_valid_reg || !slot_stall)
        begin
            if (skid_full_reg)
            begin
                slot_reg <= skid_reg;
            end
            else if (m2_valid)
            begin
                slot_reg <= pipe_slot;
            end
        end
        else if (!skid_full_reg && m2_valid)
        begin
            skid_reg <= pipe_slot;
        end
    end

    assign slot_valid = slot_valid_reg;
    assign slot       = slot_reg;

endmodule

[design/uhf_sum.sv]
// product and sum pipeline: four halfword products plus offset
// depends on uhf_pkg
module uhf_sum
    import uhf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  key_t  key,
    input  word_t coef_0,
    input  word_t coef_1,
    input  word_t coef_2,
    input  word_t coef_3,
    input  word_t offset,
    output logic  out_valid,
    output sum_t  sum
);

    logic [3:0] v_reg;
    key_t key_reg;
    logic [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [PROD_W:0] a_reg;
    logic [PROD_W+1:0] b_reg;
    sum_t sum_reg;
    logic [HALF_W-1:0] h3;

    // negative zero hashes as all halfwords zero
    assign h3 = (key_reg == NEG_ZERO) ? '0 : key_reg[63:48];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // input, products, partial sums, final sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg <= key;
            p0_reg  <= {{HALF_W{1'b0}}, coef_0} * {{WORD_W{1'b0}}, key_reg[15:0]};
            p1_reg  <= {{HALF_W{1'b0}}, coef_1} * {{WORD_W{1'b0}}, key_reg[31:16]};
            p2_reg  <= {{HALF_W{1'b0}}, coef_2} * {{WORD_W{1'b0}}, key_reg[47:32]};
            p3_reg  <= {{HALF_W{1'b0}}, coef_3} * {{WORD_W{1'b0}}, h3};
            a_reg   <= {1'b0, p0_reg} + {1'b0, p1_reg};
            b_reg   <= {2'b0, p2_reg} + {2'b0, p3_reg} + {{(PROD_W+2-WORD_W){1'b0}}, offset};
            sum_reg <= {2'b0, a_reg} + {1'b0, b_reg};
        end
    end

    assign out_valid = v_reg[3];
    assign sum       = sum_reg;

endmodule

[design/uhf_mod.sv]
// pipelined restoring remainder, one dividend bit per stage
// depends on uhf_pkg for default widths
module uhf_mod
    import uhf_pkg::*;
#(
    parameter int DW = SUM_W,
    parameter int RW = WORD_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,
    input  logic [RW-1:0] divisor,
    output logic          out_valid,
    output logic [RW-1:0] rem
);

    logic          st_v [DW+1];
    logic [RW-1:0] st_r [DW+1];
    logic [DW-1:0] st_d [DW+1];

    assign st_v[0] = in_valid;
    assign st_r[0] = '0;
    assign st_d[0] = dividend;

    for (genvar k = 0; k < DW; k++)
    begin : g_stage
        logic          v_reg;
        logic [RW-1:0] r_reg;
        logic [DW-1:0] d_reg;
        logic [RW:0]   t;
        logic [RW:0]   diff;
        logic [RW-1:0] r_next;

        // shift in the next dividend bit, subtract when it fits
        always_comb
        begin
            t      = {st_r[k], st_d[k][DW-1]};
            diff   = t - {1'b0, divisor};
            r_next = (t >= {1'b0, divisor}) ? diff[RW-1:0] : t[RW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (adv)
            begin
                v_reg <= st_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg <= r_next;
                d_reg <= {st_d[k][DW-2:0], 1'b0};
            end
        end

        assign st_v[k+1] = v_reg;
        assign st_r[k+1] = r_reg;
        assign st_d[k+1] = d_reg;
    end

    assign out_valid = st_v[DW];
    assign rem       = st_r[DW];

endmodule
